// ----- design/assert_macros.svh -----
// assertion macros used by the filter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/tkf_pkg.sv -----
// types, constants and helpers of the tilt angle kalman filter
`default_nettype none
package tkf_pkg;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CORDIC = 8'b0000_0010,
      ST_LAUNCH = 8'b0000_0100,
      ST_MUL    = 8'b0000_1000,
      ST_MRND   = 8'b0001_0000,
      ST_DIV    = 8'b0010_0000,
      ST_APPLY  = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   typedef enum logic [3:0] {
      OP_PRED_ANGLE,
      OP_PRED_CROSS,
      OP_PRED_P00,
      OP_PRED_P11,
      OP_GAIN0,
      OP_GAIN1,
      OP_CORR_ANGLE,
      OP_CORR_BIAS,
      OP_CORR_P10,
      OP_CORR_P11,
      OP_CORR_P00,
      OP_CORR_P01
   } op_type;

   localparam logic [1:0] CSR_TIME_STEP     = 2'd0;
   localparam logic [1:0] CSR_ANGLE_NOISE   = 2'd1;
   localparam logic [1:0] CSR_BIAS_NOISE    = 2'd2;
   localparam logic [1:0] CSR_MEASURE_NOISE = 2'd3;

   localparam logic [31:0] RST_TIME_STEP     = 32'd167772;
   localparam logic [31:0] RST_ANGLE_NOISE   = 32'd16777;
   localparam logic [31:0] RST_BIAS_NOISE    = 32'd50331;
   localparam logic [31:0] RST_MEASURE_NOISE = 32'd503316;

   localparam logic signed [25:0] DEG90  = 26'sd5898240;
   localparam logic [47:0]        P_MAX  = 48'h7FFF_FFFF_FFFF;
   localparam logic [127:0]       BIG    = 128'h4000_0000_0000_0000;
   localparam int                 DIV_STEPS = 78;

   // atan(2^-i) in degrees, q7.16
   function automatic logic [22:0] atan_deg(input logic [4:0] idx);
      logic [22:0] v;
      case (idx)
         5'd0:    v = 23'd2949120;
         5'd1:    v = 23'd1740967;
         5'd2:    v = 23'd919879;
         5'd3:    v = 23'd466945;
         5'd4:    v = 23'd234379;
         5'd5:    v = 23'd117304;
         5'd6:    v = 23'd58666;
         5'd7:    v = 23'd29335;
         5'd8:    v = 23'd14668;
         5'd9:    v = 23'd7334;
         5'd10:   v = 23'd3667;
         5'd11:   v = 23'd1833;
         5'd12:   v = 23'd917;
         5'd13:   v = 23'd458;
         5'd14:   v = 23'd229;
         5'd15:   v = 23'd115;
         5'd16:   v = 23'd57;
         5'd17:   v = 23'd29;
         5'd18:   v = 23'd14;
         5'd19:   v = 23'd7;
         5'd20:   v = 23'd4;
         5'd21:   v = 23'd2;
         5'd22:   v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v[64:31] == {34{v[64]}}) begin
         r = v[31:0];
      end else begin
         r = v[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [64:0] v);
      logic signed [47:0] r;
      if (v[64:47] == {18{v[64]}}) begin
         r = v[47:0];
      end else begin
         r = v[64] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
      end
      return r;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

endpackage
`default_nettype wire

// ----- design/tilt_angle_kalman_filter_core.sv -----
// tilt angle from accelerometer pair through cordic, then angle/bias kalman filter
// cordic is skipped when z is zero; the filter micro-ops then run one at a time:
// one cordic iteration per cycle, ten 64x64 products on one 64x16 multiplier
// and two 78-step restoring divisions
// a new word is taken only once the last result is loaded; req_tready is low while busy
// reset: synchronous active high; clears estimates and covariance, loads csr defaults
`default_nettype none
`include "assert_macros.svh"
module tilt_angle_kalman_filter_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // vertical_accel[15:0], tilt_accel[31:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,   // raw_tilt[23:0], filtered_angle[55:24],
                                         // bias_estimate[87:56]
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);

   localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
   localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

   tkf_pkg::state_type state_ff, state_in;
   tkf_pkg::op_type    op_ff, op_in;

   logic [31:0] dt_ff, dt_in, an_ff, an_in, bn_ff, bn_in, mn_ff, mn_in;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [47:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [23:0] raw_ff, raw_in;
   logic signed [35:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [25:0] cang_ff, cang_in;
   logic [4:0]         cstep_ff, cstep_in;
   logic signed [63:0] tmp_ff, tmp_in;
   logic signed [33:0] yv_ff, yv_in;
   logic signed [47:0] k0_ff, k0_in, k1_ff, k1_in;
   logic [63:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic               mneg_ff, mneg_in, msh30_ff, msh30_in;
   logic [127:0]       macc_ff, macc_in;
   logic [1:0]         mcnt_ff, mcnt_in;
   logic signed [63:0] mres_ff, mres_in;
   logic [77:0]        dn_ff, dn_in;
   logic [48:0]        dd_ff, dd_in, drem_ff, drem_in;
   logic [47:0]        dq_ff, dq_in;
   logic               dneg_ff, dneg_in;
   logic [6:0]         dcnt_ff, dcnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [87:0]        rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic signed [15:0] z_w, axis_w;
   logic signed [16:0] z_abs, y_init;
   logic signed [35:0] cdx, cdy, cx_nx, cy_nx;
   logic signed [25:0] cang_nx, atan_w;
   logic signed [63:0] m64, a64, b64, op_a, op_b, r64;
   logic               op_sh30;
   logic signed [64:0] rx;
   logic signed [49:0] den;
   logic signed [47:0] num;
   logic [49:0]        den_mag;
   logic [79:0]        mprod;
   logic [127:0]       rnd, rq;
   logic [62:0]        rmag;
   logic [49:0]        rem_sh;
   logic               dge;
   logic [48:0]        q_sh;
   logic signed [47:0] kq;

   assign req_tready = (state_ff == tkf_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign z_w    = req_tdata[15:0];
   assign axis_w = req_tdata[31:16];
   assign z_abs  = z_w[15] ? -{z_w[15], z_w} : {z_w[15], z_w};
   assign y_init = z_w[15] ? -{axis_w[15], axis_w} : {axis_w[15], axis_w};

   // one cordic rotation
   assign cdx    = cy_ff >>> cstep_ff;
   assign cdy    = cx_ff >>> cstep_ff;
   assign atan_w = {3'b000, tkf_pkg::atan_deg(cstep_ff)};
   always_comb begin
      if (!cy_ff[35]) begin
         cx_nx   = cx_ff + cdx;
         cy_nx   = cy_ff - cdy;
         cang_nx = cang_ff + atan_w;
      end else begin
         cx_nx   = cx_ff - cdx;
         cy_nx   = cy_ff + cdy;
         cang_nx = cang_ff - atan_w;
      end
   end

   assign m64 = {{40{raw_ff[23]}}, raw_ff};
   assign a64 = {{32{ang_ff[31]}}, ang_ff};
   assign b64 = {{32{bias_ff[31]}}, bias_ff};

   // operand select for each multiplier micro-op
   always_comb begin
      op_a    = '0;
      op_b    = '0;
      op_sh30 = 1'b0;
      case (op_ff)
         tkf_pkg::OP_PRED_ANGLE: begin
            op_a = m64 - b64;
            op_b = {32'd0, dt_ff};
         end
         tkf_pkg::OP_PRED_CROSS: begin
            op_a = {32'd0, dt_ff};
            op_b = {{16{p11_ff[47]}}, p11_ff};
         end
         tkf_pkg::OP_PRED_P00: begin
            op_a = {32'd0, dt_ff};
            op_b = tmp_ff;
         end
         tkf_pkg::OP_PRED_P11: begin
            op_a = {32'd0, bn_ff};
            op_b = {32'd0, dt_ff};
         end
         tkf_pkg::OP_CORR_ANGLE: begin
            op_a = {{16{k0_ff[47]}}, k0_ff};
            op_b = m64 - a64;
            op_sh30 = 1'b1;
         end
         tkf_pkg::OP_CORR_BIAS: begin
            op_a = {{16{k1_ff[47]}}, k1_ff};
            op_b = {{30{yv_ff[33]}}, yv_ff};
            op_sh30 = 1'b1;
         end
         tkf_pkg::OP_CORR_P10: begin
            op_a = {{16{k1_ff[47]}}, k1_ff};
            op_b = {{16{p00_ff[47]}}, p00_ff};
            op_sh30 = 1'b1;
         end
         tkf_pkg::OP_CORR_P11: begin
            op_a = {{16{k1_ff[47]}}, k1_ff};
            op_b = {{16{p01_ff[47]}}, p01_ff};
            op_sh30 = 1'b1;
         end
         tkf_pkg::OP_CORR_P00: begin
            op_a = {{16{k0_ff[47]}}, k0_ff};
            op_b = {{16{p00_ff[47]}}, p00_ff};
            op_sh30 = 1'b1;
         end
         tkf_pkg::OP_CORR_P01: begin
            op_a = {{16{k0_ff[47]}}, k0_ff};
            op_b = {{16{p01_ff[47]}}, p01_ff};
            op_sh30 = 1'b1;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   // innovation variance and gain numerator
   assign den     = {{2{p00_ff[47]}}, p00_ff} + {18'd0, mn_ff};
   assign num     = (op_ff == tkf_pkg::OP_GAIN0) ? p00_ff : p10_ff;
   assign den_mag = den[49] ? 50'(-den) : 50'(den);

   // multiplier digit step and rounding
   assign mprod = ma_ff * mb_ff[63:48];
   assign rnd   = macc_ff + (msh30_ff ? (128'd1 << 29) : (128'd1 << 23));
   assign rq    = msh30_ff ? (rnd >> 30) : (rnd >> 24);
   assign rmag  = (rq > tkf_pkg::BIG) ? tkf_pkg::BIG[62:0] : rq[62:0];

   // divider step
   assign rem_sh = {drem_ff, dn_ff[77]};
   assign dge    = rem_sh >= {1'b0, dd_ff};
   assign q_sh   = {dq_ff, dge};
   assign kq     = (dd_ff == '0) ? 48'sd0 : (dneg_ff ? 48'(-dq_ff) : 48'(dq_ff));

   assign r64 = mres_ff;
   assign rx  = {r64[63], r64};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      dt_in        = dt_ff;
      an_in        = an_ff;
      bn_in        = bn_ff;
      mn_in        = mn_ff;
      ang_in       = ang_ff;
      bias_in      = bias_ff;
      p00_in       = p00_ff;
      p01_in       = p01_ff;
      p10_in       = p10_ff;
      p11_in       = p11_ff;
      raw_in       = raw_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cang_in      = cang_ff;
      cstep_in     = cstep_ff;
      tmp_in       = tmp_ff;
      yv_in        = yv_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      mneg_in      = mneg_ff;
      msh30_in     = msh30_ff;
      macc_in      = macc_ff;
      mcnt_in      = mcnt_ff;
      mres_in      = mres_ff;
      dn_in        = dn_ff;
      dd_in        = dd_ff;
      drem_in      = drem_ff;
      dq_in        = dq_ff;
      dneg_in      = dneg_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wen) begin
         case (csr_addr)
            tkf_pkg::CSR_TIME_STEP:     dt_in = csr_wdata;
            tkf_pkg::CSR_ANGLE_NOISE:   an_in = csr_wdata;
            tkf_pkg::CSR_BIAS_NOISE:    bn_in = csr_wdata;
            tkf_pkg::CSR_MEASURE_NOISE: mn_in = csr_wdata;
            default:                    dt_in = dt_ff;
         endcase
      end

      case (state_ff)
         tkf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = tkf_pkg::OP_PRED_ANGLE;
               cx_in    = {3'b000, z_abs, 16'd0};
               cy_in    = {{3{y_init[16]}}, y_init, 16'd0};
               cang_in  = '0;
               cstep_in = '0;
               if (z_w == '0) begin
                  // vertical reading zero: straight up or down
                  raw_in   = axis_w[15] ? 24'(-tkf_pkg::DEG90) : 24'(tkf_pkg::DEG90);
                  state_in = tkf_pkg::ST_LAUNCH;
               end else begin
                  state_in = tkf_pkg::ST_CORDIC;
               end
            end
         end
         tkf_pkg::ST_CORDIC: begin
            cx_in    = cx_nx;
            cy_in    = cy_nx;
            cang_in  = cang_nx;
            cstep_in = cstep_ff + 5'd1;
            if (cstep_ff == LAST_STEP) begin
               if (cang_nx > tkf_pkg::DEG90) begin
                  raw_in = 24'(tkf_pkg::DEG90);
               end else if (cang_nx < -tkf_pkg::DEG90) begin
                  raw_in = 24'(-tkf_pkg::DEG90);
               end else begin
                  raw_in = cang_nx[23:0];
               end
               state_in = tkf_pkg::ST_LAUNCH;
            end
         end
         tkf_pkg::ST_LAUNCH: begin
            if (op_ff == tkf_pkg::OP_GAIN0 || op_ff == tkf_pkg::OP_GAIN1) begin
               dn_in    = {(num[47] ? 48'(-num) : 48'(num)), 30'd0};
               dd_in    = den_mag[48:0];
               drem_in  = '0;
               dq_in    = '0;
               dneg_in  = num[47] ^ den[49];
               dcnt_in  = '0;
               state_in = tkf_pkg::ST_DIV;
            end else begin
               ma_in    = tkf_pkg::mag64(op_a);
               mb_in    = tkf_pkg::mag64(op_b);
               mneg_in  = op_a[63] ^ op_b[63];
               msh30_in = op_sh30;
               macc_in  = '0;
               mcnt_in  = '0;
               if (op_ff == tkf_pkg::OP_CORR_ANGLE) begin
                  yv_in = op_b[33:0];
               end
               state_in = tkf_pkg::ST_MUL;
            end
         end
         tkf_pkg::ST_MUL: begin
            // most significant 16-bit digit of b first
            macc_in = {macc_ff[111:0], 16'd0} + {48'd0, mprod};
            mb_in   = {mb_ff[47:0], 16'd0};
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) begin
               state_in = tkf_pkg::ST_MRND;
            end
         end
         tkf_pkg::ST_MRND: begin
            mres_in  = mneg_ff ? -{1'b0, rmag} : {1'b0, rmag};
            state_in = tkf_pkg::ST_APPLY;
         end
         tkf_pkg::ST_DIV: begin
            dn_in   = {dn_ff[76:0], 1'b0};
            drem_in = dge ? 49'(rem_sh - {1'b0, dd_ff}) : rem_sh[48:0];
            dq_in   = (q_sh > {1'b0, tkf_pkg::P_MAX}) ? tkf_pkg::P_MAX : q_sh[47:0];
            dcnt_in = dcnt_ff + 7'd1;
            if (dcnt_ff == 7'(tkf_pkg::DIV_STEPS - 1)) begin
               state_in = tkf_pkg::ST_APPLY;
            end
         end
         tkf_pkg::ST_APPLY: begin
            case (op_ff)
               tkf_pkg::OP_PRED_ANGLE: ang_in = tkf_pkg::sat32({{33{ang_ff[31]}}, ang_ff} + rx);
               tkf_pkg::OP_PRED_CROSS: begin
                  tmp_in = r64 - {{16{p01_ff[47]}}, p01_ff} - {{16{p10_ff[47]}}, p10_ff}
                           + {32'd0, an_ff};
                  p01_in = tkf_pkg::sat48({{17{p01_ff[47]}}, p01_ff} - rx);
                  p10_in = tkf_pkg::sat48({{17{p10_ff[47]}}, p10_ff} - rx);
               end
               tkf_pkg::OP_PRED_P00:   p00_in = tkf_pkg::sat48({{17{p00_ff[47]}}, p00_ff} + rx);
               tkf_pkg::OP_PRED_P11:   p11_in = tkf_pkg::sat48({{17{p11_ff[47]}}, p11_ff} + rx);
               tkf_pkg::OP_GAIN0:      k0_in = kq;
               tkf_pkg::OP_GAIN1:      k1_in = kq;
               tkf_pkg::OP_CORR_ANGLE: ang_in = tkf_pkg::sat32({{33{ang_ff[31]}}, ang_ff} + rx);
               tkf_pkg::OP_CORR_BIAS:  bias_in = tkf_pkg::sat32({{33{bias_ff[31]}}, bias_ff} + rx);
               tkf_pkg::OP_CORR_P10:   p10_in = tkf_pkg::sat48({{17{p10_ff[47]}}, p10_ff} - rx);
               tkf_pkg::OP_CORR_P11:   p11_in = tkf_pkg::sat48({{17{p11_ff[47]}}, p11_ff} - rx);
               tkf_pkg::OP_CORR_P00:   p00_in = tkf_pkg::sat48({{17{p00_ff[47]}}, p00_ff} - rx);
               tkf_pkg::OP_CORR_P01:   p01_in = tkf_pkg::sat48({{17{p01_ff[47]}}, p01_ff} - rx);
               default:                ang_in = ang_ff;
            endcase
            if (op_ff == tkf_pkg::OP_CORR_P01) begin
               state_in = tkf_pkg::ST_DONE;
            end else begin
               op_in    = tkf_pkg::op_type'(op_ff + 4'd1);
               state_in = tkf_pkg::ST_LAUNCH;
            end
         end
         tkf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {bias_ff, ang_ff, raw_ff};
               state_in     = tkf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tkf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tkf_pkg::ST_IDLE;
         op_ff        <= tkf_pkg::OP_PRED_ANGLE;
         rsp_valid_ff <= 1'b0;
         dt_ff        <= tkf_pkg::RST_TIME_STEP;
         an_ff        <= tkf_pkg::RST_ANGLE_NOISE;
         bn_ff        <= tkf_pkg::RST_BIAS_NOISE;
         mn_ff        <= tkf_pkg::RST_MEASURE_NOISE;
         ang_ff       <= '0;
         bias_ff      <= '0;
         p00_ff       <= '0;
         p01_ff       <= '0;
         p10_ff       <= '0;
         p11_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         dt_ff        <= dt_in;
         an_ff        <= an_in;
         bn_ff        <= bn_in;
         mn_ff        <= mn_in;
         ang_ff       <= ang_in;
         bias_ff      <= bias_in;
         p00_ff       <= p00_in;
         p01_ff       <= p01_in;
         p10_ff       <= p10_in;
         p11_ff       <= p11_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cang_ff     <= cang_in;
      cstep_ff    <= cstep_in;
      tmp_ff      <= tmp_in;
      yv_ff       <= yv_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      mneg_ff     <= mneg_in;
      msh30_ff    <= msh30_in;
      macc_ff     <= macc_in;
      mcnt_ff     <= mcnt_in;
      mres_ff     <= mres_in;
      dn_ff       <= dn_in;
      dd_ff       <= dd_in;
      drem_ff     <= drem_in;
      dq_ff       <= dq_in;
      dneg_ff     <= dneg_in;
      dcnt_ff     <= dcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "accepted a word while busy")
   `ASSERT_IMP(a_quot_sat, clock, reset, state_ff == tkf_pkg::ST_DIV, dq_ff <= tkf_pkg::P_MAX, "gain quotient above limit")
   `ASSERT_IMP(a_prod_sat, clock, reset, state_ff == tkf_pkg::ST_APPLY && op_ff != tkf_pkg::OP_GAIN0 && op_ff != tkf_pkg::OP_GAIN1, (mres_ff <= 64'sh4000_0000_0000_0000) && (mres_ff >= -64'sh4000_0000_0000_0000), "product beyond saturation bound")
   `ASSERT_NXT(a_done_delivers, clock, reset, state_ff == tkf_pkg::ST_DONE && (!rsp_valid_ff || rsp_tready), rsp_valid_ff && state_ff == tkf_pkg::ST_IDLE, "result not loaded on finish")

endmodule
`default_nettype wire

// ----- tb/tb_tilt_angle_kalman_filter_core.sv -----
// testbench of the tilt angle kalman filter core: directed table, random words, live prediction
`timescale 1ns / 100ps
`default_nettype none
module tb_tilt_angle_kalman_filter_core;

   localparam longint COV_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint I32_MAX = 64'sd2147483647;
   localparam longint ROUND_CAP = 64'sh4000_0000_0000_0000;
   localparam int     RIGHT_ANGLE = 5898240;
   localparam int     SETTLE_CYCLES = 300;
   localparam int     HOLD_CYCLES = 3000;

   localparam int ATAN_TBL [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                    58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                    229, 115};

   // fields from the highest bits down, so raw_tilt lands in the lowest bits
   typedef struct packed {
      logic signed [31:0] bias;
      logic signed [31:0] angle;
      logic signed [23:0] raw_tilt;
   } tilt_result_type;

   typedef struct {
      logic [15:0]        vert;
      logic [15:0]        tilt;
      bit                 raw_known;
      logic signed [23:0] raw_val;
   } tilt_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   tilt_angle_kalman_filter_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow of the filter
   logic [31:0] sh_time_step, sh_angle_noise, sh_bias_noise, sh_measure_noise;
   int          sh_angle, sh_bias;
   longint      sh_cov [4];

   tilt_result_type pending_results [$];
   int              errors = 0;
   int              words_sent = 0;
   int              words_seen = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s at result %0d: got %h expected %h", what, words_seen, got, want);
      errors++;
   endtask

   function automatic longint clampv(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim - 1) return -lim - 1;
      return v;
   endfunction

   // rounded product a*b/2^sh, halves away from zero, magnitude capped at 2^62
   function automatic longint mul_round(input longint a, input longint b, input int sh);
      logic [127:0] ua, ub, pr;
      logic         neg;
      neg = (a < 0) != (b < 0);
      ua = {64'd0, 64'(a < 0 ? -a : a)};
      ub = {64'd0, 64'(b < 0 ? -b : b)};
      pr = ua * ub + (128'd1 << (sh - 1));
      pr = pr >> sh;
      if (pr > 128'(ROUND_CAP)) pr = 128'(ROUND_CAP);
      return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
   endfunction

   // restoring division with running saturation of the quotient
   function automatic longint div_gain(input longint num, input longint den, input int f);
      logic [63:0] n, d, rem, q, nb;
      logic        neg;
      neg = (num < 0) != (den < 0);
      n = 64'(num < 0 ? -num : num);
      d = 64'(den < 0 ? -den : den);
      rem = '0;
      q = '0;
      if (d == 0) return 0;
      for (int i = 64 + f - 1; i >= 0; i--) begin
         nb = (i >= f) ? ((n >> (i - f)) & 64'd1) : 64'd0;
         rem = (rem << 1) | nb;
         q = q << 1;
         if (rem >= d) begin
            rem = rem - d;
            q[0] = 1'b1;
         end
         if (q > 64'(COV_MAX)) q = 64'(COV_MAX);
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic int tilt_deg(input longint z, input longint ax);
      longint x, y, ang, dx, dy;
      ang = 0;
      if (z == 0) return (ax < 0) ? -RIGHT_ANGLE : RIGHT_ANGLE;
      x = (z < 0 ? -z : z) * 65536;
      y = (z < 0 ? -ax : ax) * 65536;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; ang += ATAN_TBL[i];
         end else begin
            x -= dx; y += dy; ang -= ATAN_TBL[i];
         end
      end
      if (ang > RIGHT_ANGLE) ang = RIGHT_ANGLE;
      if (ang < -RIGHT_ANGLE) ang = -RIGHT_ANGLE;
      return int'(ang);
   endfunction

   function automatic tilt_result_type filter_word(input logic [15:0] vz,
                                                   input logic [15:0] va);
      tilt_result_type r;
      longint m, a, b, dt, p00, p01, p10, p11, t, s, k0, k1, y;
      m = tilt_deg(longint'($signed(vz)), longint'($signed(va)));
      a = sh_angle;
      b = sh_bias;
      dt = longint'({32'd0, sh_time_step});
      p00 = sh_cov[0]; p01 = sh_cov[1]; p10 = sh_cov[2]; p11 = sh_cov[3];
      // predict, measured angle in place of a rate
      a = clampv(a + mul_round(m - b, dt, 24), I32_MAX);
      t = mul_round(dt, p11, 24) - p01 - p10 + longint'({32'd0, sh_angle_noise});
      p00 = clampv(p00 + mul_round(dt, t, 24), COV_MAX);
      p01 = clampv(p01 - mul_round(dt, p11, 24), COV_MAX);
      p10 = clampv(p10 - mul_round(dt, p11, 24), COV_MAX);
      p11 = clampv(p11 + mul_round(longint'({32'd0, sh_bias_noise}), dt, 24), COV_MAX);
      s = p00 + longint'({32'd0, sh_measure_noise});
      k0 = div_gain(p00, s, 30);
      k1 = div_gain(p10, s, 30);
      y = m - a;
      a = clampv(a + mul_round(k0, y, 30), I32_MAX);
      b = clampv(b + mul_round(k1, y, 30), I32_MAX);
      t = p01;
      s = p00;
      p00 = clampv(s - mul_round(k0, s, 30), COV_MAX);
      p01 = clampv(t - mul_round(k0, t, 30), COV_MAX);
      p10 = clampv(p10 - mul_round(k1, s, 30), COV_MAX);
      p11 = clampv(p11 - mul_round(k1, t, 30), COV_MAX);
      sh_angle = int'(a);
      sh_bias = int'(b);
      sh_cov[0] = p00; sh_cov[1] = p01; sh_cov[2] = p10; sh_cov[3] = p11;
      r.raw_tilt = 24'(m);
      r.angle = 32'(a);
      r.bias = 32'(b);
      return r;
   endfunction

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         tkf_pkg::CSR_TIME_STEP:   sh_time_step = val;
         tkf_pkg::CSR_ANGLE_NOISE: sh_angle_noise = val;
         tkf_pkg::CSR_BIAS_NOISE:  sh_bias_noise = val;
         default:                  sh_measure_noise = val;
      endcase
   endtask

   task automatic set_filter(input logic [31:0] ts, an, bn, mn);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(tkf_pkg::CSR_TIME_STEP, ts);
      write_csr(tkf_pkg::CSR_ANGLE_NOISE, an);
      write_csr(tkf_pkg::CSR_BIAS_NOISE, bn);
      write_csr(tkf_pkg::CSR_MEASURE_NOISE, mn);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic send_word(input logic [15:0] vz, input logic [15:0] va,
                            input bit raw_known, input logic signed [23:0] raw_val);
      tilt_result_type r;
      bit quiet;
      quiet = (words_sent >= 700 && words_sent < 1000);
      while (!quiet && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {va, vz};
      do @(posedge clock); while (!req_tready);
      r = filter_word(vz, va);
      if (raw_known) r.raw_tilt = raw_val;
      pending_results.push_back(r);
      words_sent++;
   endtask

   function automatic logic [15:0] rand_accel();
      case ($urandom_range(7))
         0, 1, 2: return 16'($urandom);
         3:       return 16'($urandom_range(512) - 256);
         4:       return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
         5:       return 16'($urandom_range(3) - 1);
         default: return 16'($urandom_range(20000) - 10000);
      endcase
   endfunction

   task automatic send_random(input int count);
      logic [15:0] vz;
      for (int i = 0; i < count; i++) begin
         vz = ($urandom_range(9) == 0) ? 16'd0 : rand_accel();
         send_word(vz, rand_accel(), 1'b0, '0);
      end
      @(posedge clock);
      req_tvalid <= 1'b0;
   endtask

   // receive side, with one long hold-off to back the block up
   initial begin
      tilt_result_type got, want;
      int hold;
      bit quiet;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_results.size() == 0) begin
               report("unexpected word", longint'(rsp_tdata[63:0]), 0);
            end else begin
               want = pending_results.pop_front();
               if (got.raw_tilt !== want.raw_tilt) report("raw_tilt", got.raw_tilt, want.raw_tilt);
               if (got.angle !== want.angle) report("filtered_angle", got.angle, want.angle);
               if (got.bias !== want.bias) report("bias_estimate", got.bias, want.bias);
            end
            words_seen++;
            if (words_seen == 200) hold = HOLD_CYCLES;
         end
         quiet = (words_seen >= 700 && words_seen < 1000);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= 23);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("tilt_angle_kalman_filter_core verification failed");
      $finish;
   end

   initial begin
      tilt_row_type rows [$];
      sh_time_step = tkf_pkg::RST_TIME_STEP;
      sh_angle_noise = tkf_pkg::RST_ANGLE_NOISE;
      sh_bias_noise = tkf_pkg::RST_BIAS_NOISE;
      sh_measure_noise = tkf_pkg::RST_MEASURE_NOISE;
      sh_angle = 0;
      sh_bias = 0;
      foreach (sh_cov[i]) sh_cov[i] = 0;
      // zero z first, with zero angle and measurement noise, so the innovation variance starts at zero
      rows = '{
         '{16'h0000, 16'h0000, 1, 24'(RIGHT_ANGLE)},
         '{16'h0000, 16'hFFFF, 1, -24'(RIGHT_ANGLE)},
         '{16'h0000, 16'h7FFF, 1, 24'(RIGHT_ANGLE)},
         '{16'h0000, 16'h8000, 1, -24'(RIGHT_ANGLE)},
         '{16'h7FFF, 16'h0000, 0, '0},
         '{16'h8000, 16'h0000, 0, '0},
         '{16'h7FFF, 16'h7FFF, 0, '0},
         '{16'h8000, 16'h8000, 0, '0},
         '{16'h7FFF, 16'h8000, 0, '0},
         '{16'h8000, 16'h7FFF, 0, '0},
         '{16'h0001, 16'h7FFF, 0, '0},
         '{16'h0001, 16'h8000, 0, '0},
         '{16'hFFFF, 16'h7FFF, 0, '0},
         '{16'hFFFF, 16'h8000, 0, '0},
         '{16'h0001, 16'h0001, 0, '0},
         '{16'hFFFF, 16'hFFFF, 0, '0},
         '{16'h4000, 16'h2000, 0, '0},
         '{16'hC000, 16'h2000, 0, '0},
         '{16'h1234, 16'hEDCB, 0, '0},
         '{16'h5555, 16'hAAAA, 0, '0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      set_filter(tkf_pkg::RST_TIME_STEP, 32'd0, tkf_pkg::RST_BIAS_NOISE, 32'd0);
      foreach (rows[i]) send_word(rows[i].vert, rows[i].tilt, rows[i].raw_known, rows[i].raw_val);
      @(posedge clock);
      req_tvalid <= 1'b0;
      set_filter(tkf_pkg::RST_TIME_STEP, tkf_pkg::RST_ANGLE_NOISE, tkf_pkg::RST_BIAS_NOISE,
                 tkf_pkg::RST_MEASURE_NOISE);
      send_random(500);
      set_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_random(250);
      set_filter(32'd0, 32'd0, 32'd0, 32'd0);
      send_random(150);
      for (int p = 0; p < 3; p++) begin
         set_filter($urandom, $urandom_range(1 << 22), $urandom, $urandom_range(1 << 24));
         send_random(250);
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tilt_angle_kalman_filter_core verification clean");
      end else begin
         $display("tilt_angle_kalman_filter_core verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
